// ===== src/assert_macros.svh =====
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion helpers for the RTL in this folder.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef SYNTHESIS

// Property checked at every rising clock edge outside of reset.
`define ASSERT_CLK(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed in prefix integer decoder");

// Condition that must never be true outside of reset.
`define ASSERT_NEVER(label, clk, rst_n, cond) \
    label: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error("forbidden condition in prefix integer decoder");

`else

`define ASSERT_CLK(label, clk, rst_n, prop)
`define ASSERT_NEVER(label, clk, rst_n, cond)

`endif

`endif

// ===== src/pidec_pkg.sv =====
// ----------------------------------------------------------------------------
// Prefix integer decoder package
// Types and constants shared by the decoder step logic and the core.
// ----------------------------------------------------------------------------
package pidec_pkg;

    localparam int unsigned VALUE_W   = 16;
    localparam int unsigned SHIFT_W   = 5;
    localparam int unsigned SUM_W     = 29;
    localparam logic [SHIFT_W-1:0] SHIFT_MAX  = 5'd21;
    localparam logic [SHIFT_W-1:0] SHIFT_STEP = 5'd7;
    localparam logic [3:0]         PREFIX_MAX = 4'd8;

    // Result status codes.
    typedef enum logic [2:0] {
        ST_MORE     = 3'd0,
        ST_DONE     = 3'd1,
        ST_OVERFLOW = 3'd2,
        ST_TRUNC    = 3'd3,
        ST_IGNORED  = 3'd4
    } status_t;

    // Decoder state carried between bytes.
    typedef struct packed {
        logic [VALUE_W-1:0] acc;
        logic [SHIFT_W-1:0] shift;
        logic               open;
    } pidec_state_t;

    // One result beat.
    typedef struct packed {
        status_t            status;
        logic [VALUE_W-1:0] value;
    } pidec_result_t;

endpackage

// ===== src/pidec_step.sv =====
// ----------------------------------------------------------------------------
// Prefix integer decoder step
// Combinational decode of one byte against the current decoder state.
// ----------------------------------------------------------------------------
module pidec_step
(
    input  logic [7:0]             data_byte,
    input  logic                   first,
    input  logic [3:0]             prefix_bits,
    input  logic                   buffer_end,
    input  pidec_pkg::pidec_state_t st,
    output pidec_pkg::pidec_state_t st_next,
    output pidec_pkg::pidec_result_t res
);
    import pidec_pkg::*;

    logic [3:0]         prefix_sat;
    logic [7:0]         ones;
    logic [7:0]         low;
    logic [VALUE_W-1:0] cont_acc;
    logic [SHIFT_W-1:0] cont_sh;
    logic [SHIFT_W-1:0] sh_next;
    logic [SUM_W-1:0]   addend;
    logic [SUM_W-1:0]   sum;
    logic               overflow;

    // Prefix width clamp and all-ones mask of the prefix.
    assign prefix_sat = (prefix_bits > PREFIX_MAX) ? PREFIX_MAX : prefix_bits;
    assign ones       = 8'hff >> (PREFIX_MAX - prefix_sat);
    assign low        = data_byte & ones;

    // Continuation operands: a first byte with no prefix starts from zero.
    assign cont_acc = first ? '0 : st.acc;
    assign cont_sh  = first ? '0 : ((st.shift > SHIFT_MAX) ? SHIFT_MAX : st.shift);
    assign addend   = {{(SUM_W-7){1'b0}}, data_byte[6:0]} << cont_sh;
    assign sum      = {{(SUM_W-VALUE_W){1'b0}}, cont_acc} + addend;
    assign overflow = |sum[SUM_W-1:VALUE_W];
    assign sh_next  = ((cont_sh + SHIFT_STEP) > SHIFT_MAX) ? SHIFT_MAX : cont_sh + SHIFT_STEP;

    // Decode decision. A closed integer leaves the state cleared.
    always_comb
    begin
        st_next    = '0;
        res.status = ST_IGNORED;
        res.value  = '0;
        if (first && (prefix_sat != 4'd0)) begin
            if (low != ones) begin
                res.status = ST_DONE;
                res.value  = {{(VALUE_W-8){1'b0}}, low};
            end else if (buffer_end) begin
                res.status = ST_TRUNC;
            end else begin
                res.status  = ST_MORE;
                st_next.acc = {{(VALUE_W-8){1'b0}}, ones};
                st_next.open = 1'b1;
            end
        end else if (first || st.open) begin
            if (overflow) begin
                res.status = ST_OVERFLOW;
            end else if (!data_byte[7]) begin
                res.status = ST_DONE;
                res.value  = sum[VALUE_W-1:0];
            end else if (buffer_end) begin
                res.status = ST_TRUNC;
            end else begin
                res.status    = ST_MORE;
                st_next.acc   = sum[VALUE_W-1:0];
                st_next.shift = sh_next;
                st_next.open  = 1'b1;
            end
        end else begin
            // Stray byte: nothing open, state unchanged.
            st_next = st;
        end
    end

endmodule

// ===== src/prefix_integer_decoder_core.sv =====
// ----------------------------------------------------------------------------
// Prefix integer decoder core
// Decodes header-compression prefix integers one byte per beat.
// ----------------------------------------------------------------------------
// Each input beat yields exactly one result beat. A byte is captured in an
// input register, decoded combinationally against the running sum, and
// written to a result register, so the core sustains one byte per clock
// while results are taken. The result beat becomes valid when its byte moves
// from the input register into the result register, which waits while a held
// result is not taken. The running sum and shift update at that move; in_ready
// drops only when both the input and result registers are full and out_ready
// is low.
module prefix_integer_decoder_core
(
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  data_byte,
    input  logic        first,
    input  logic [3:0]  prefix_bits,
    input  logic        buffer_end,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [2:0]  status,
    output logic [15:0] value
);
    import pidec_pkg::*;

`include "assert_macros.svh"

    logic          in_valid_reg;
    logic [7:0]    byte_reg;
    logic          first_reg;
    logic [3:0]    prefix_reg;
    logic          end_reg;
    pidec_state_t  state_reg;
    pidec_state_t  state_next;
    pidec_result_t res_next;
    pidec_result_t res_reg;
    logic          out_valid_reg;
    logic          advance;

    // Pipeline handshake.
    assign advance  = in_valid_reg && (!out_valid_reg || out_ready);
    assign in_ready = !in_valid_reg || advance;

    // Input register control.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            in_valid_reg <= 1'b0;
        end else if (in_ready) begin
            in_valid_reg <= in_valid;
        end
    end

    // Input register payload.
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready) begin
            byte_reg   <= data_byte;
            first_reg  <= first;
            prefix_reg <= prefix_bits;
            end_reg    <= buffer_end;
        end
    end

    // Decode of the held byte.
    pidec_step u_step
    (
        .data_byte   (byte_reg),
        .first       (first_reg),
        .prefix_bits (prefix_reg),
        .buffer_end  (end_reg),
        .st          (state_reg),
        .st_next     (state_next),
        .res         (res_next)
    );

    // Decoder state and result valid.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= '0;
            out_valid_reg <= 1'b0;
        end else begin
            if (advance) begin
                state_reg <= state_next;
            end
            if (advance) begin
                out_valid_reg <= 1'b1;
            end else if (out_ready) begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    // Result register payload.
    always_ff @(posedge clk)
    begin
        if (advance) begin
            res_reg <= res_next;
        end
    end

    assign out_valid = out_valid_reg;
    assign status    = res_reg.status;
    assign value     = res_reg.value;

    // Checks.
    `ASSERT_CLK(a_value_only_done, clk, rst_n,
        (out_valid && (status != ST_DONE)) |-> (value == '0))
    `ASSERT_CLK(a_shift_legal, clk, rst_n,
        (state_reg.shift == 5'd0) || (state_reg.shift == 5'd7) ||
        (state_reg.shift == 5'd14) || (state_reg.shift == 5'd21))
    `ASSERT_CLK(a_closed_is_clear, clk, rst_n,
        !state_reg.open |-> ((state_reg.acc == '0) && (state_reg.shift == '0)))
    `ASSERT_CLK(a_state_holds_when_stalled, clk, rst_n,
        !advance |=> $stable(state_reg))

endmodule
